>>> src/orthogonal_circle_of_three_circles_defines.svh
// Assertion macros for the radical centre block.
// Included by the top level; no other dependencies.
`ifndef ORTHOGONAL_CIRCLE_OF_THREE_CIRCLES_DEFINES_SVH
`define ORTHOGONAL_CIRCLE_OF_THREE_CIRCLES_DEFINES_SVH
`ifndef SYNTHESIS
`define OCOTC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define OCOTC_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define OCOTC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define OCOTC_ASSERT_NEXT(lbl, clk, ante, cons)
`endif
`endif

>>> src/ocotc_pkg.sv
// Shared widths, constants and payload types for the radical centre block.
// No dependencies; used by ocotc_div and the top level.
package ocotc_pkg;

    localparam int CoordWidth  = 16;
    localparam int FracBits    = 8;
    localparam int OutFrac     = 16;
    localparam int RadSqWidth  = 32;
    localparam int CentreW     = 32;
    localparam int RadW        = 48;
    localparam int ScaleShift  = OutFrac - FracBits;

    localparam int DiffW   = CoordWidth + 1;
    localparam int SqW     = 2 * CoordWidth - 1;
    localparam int PowW    = 2 * CoordWidth + 2;
    localparam int DdTermW = 2 * CoordWidth + 1;
    localparam int DdW     = 2 * CoordWidth + 3;
    localparam int NTermW  = DiffW + PowW;
    localparam int NW      = NTermW + 2;
    localparam int UnW     = NW + ScaleShift;
    localparam int DenW    = DdW + 1;
    localparam int QuotW   = DenW;

    localparam logic signed [CentreW-1:0] CentreMax = {1'b0, {(CentreW-1){1'b1}}};
    localparam logic signed [CentreW-1:0] CentreMin = {1'b1, {(CentreW-1){1'b0}}};
    localparam logic signed [RadW-1:0]    RadMax    = {1'b0, {(RadW-1){1'b1}}};

    typedef struct packed {
        logic signed [CoordWidth-1:0] first_x;
        logic signed [CoordWidth-1:0] first_y;
        logic [RadSqWidth-1:0]        first_radius_sq;
        logic signed [CoordWidth-1:0] second_x;
        logic signed [CoordWidth-1:0] second_y;
        logic [RadSqWidth-1:0]        second_radius_sq;
        logic signed [CoordWidth-1:0] third_x;
        logic signed [CoordWidth-1:0] third_y;
        logic [RadSqWidth-1:0]        third_radius_sq;
    } in_t;

    typedef struct packed {
        logic signed [CentreW-1:0] centre_x;
        logic signed [CentreW-1:0] centre_y;
        logic signed [RadW-1:0]    orth_radius_sq;
        logic                      degenerate;
        logic                      saturated;
    } out_t;

    // sideband that rides along the divider
    typedef struct packed {
        logic                         deg;
        logic signed [CoordWidth-1:0] ax;
        logic signed [CoordWidth-1:0] ay;
        logic [RadSqWidth-1:0]        ar;
    } tag_t;

    typedef struct packed {
        logic [UnW-1:0]  un_x;
        logic            neg_x;
        logic [UnW-1:0]  un_y;
        logic            neg_y;
        logic [DenW-1:0] den;
        tag_t            tag;
    } div_req_t;

    // one lane of the restoring divider: quotient bits shift into lo
    typedef struct packed {
        logic [DenW-1:0]  rem;
        logic [QuotW-1:0] lo;
        logic             neg;
        logic             ov;
    } lane_t;

    typedef struct packed {
        lane_t           x;
        lane_t           y;
        logic [DenW-1:0] den;
        tag_t            tag;
    } div_stage_t;

endpackage

>>> src/ocotc_div.sv
// Pipelined two-lane restoring divider, one quotient bit per stage after the load stage.
// Depends on ocotc_pkg.
module ocotc_div import ocotc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       req_valid,
    output logic       req_ready,
    input  div_req_t   req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output div_stage_t rsp
);

    localparam int Stages = QuotW + 1;

    logic [Stages-1:0] v_reg;
    logic [Stages-1:0] en;
    div_stage_t        st_reg  [Stages];
    div_stage_t        st_next [Stages];

    function automatic lane_t lane_init(logic [UnW-1:0] un, logic neg, logic [DenW-1:0] den);
        lane_t l;
        l.rem = DenW'(un[UnW-1:QuotW]);
        l.lo  = un[QuotW-1:0];
        l.neg = neg;
        l.ov  = DenW'(un[UnW-1:QuotW]) >= den;
        return l;
    endfunction

    function automatic lane_t lane_step(lane_t l, logic [DenW-1:0] den);
        logic [DenW:0] t;
        logic          qb;
        lane_t         r;
        r     = l;
        t     = {l.rem, l.lo[QuotW-1]};
        qb    = t >= {1'b0, den};
        r.rem = qb ? DenW'(t - {1'b0, den}) : t[DenW-1:0];
        r.lo  = {l.lo[QuotW-2:0], qb};
        return r;
    endfunction

    // load a stage when it is empty or its successor moves
    always_comb begin
        en[Stages-1] = !v_reg[Stages-1] || rsp_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    // compute each stage's next contents
    always_comb begin
        st_next[0].x   = lane_init(req.un_x, req.neg_x, req.den);
        st_next[0].y   = lane_init(req.un_y, req.neg_y, req.den);
        st_next[0].den = req.den;
        st_next[0].tag = req.tag;
        for (int i = 1; i < Stages; i++) begin
            st_next[i]   = st_reg[i-1];
            st_next[i].x = lane_step(st_reg[i-1].x, st_reg[i-1].den);
            st_next[i].y = lane_step(st_reg[i-1].y, st_reg[i-1].den);
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= req_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < Stages; i++) begin
            if (en[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign req_ready = en[0];
    assign rsp_valid = v_reg[Stages-1];
    assign rsp       = st_reg[Stages-1];

endmodule

>>> src/orthogonal_circle_of_three_circles.sv
// Radical centre and orthogonal circle of three weighted circles, top level.
// Depends on ocotc_pkg, ocotc_div and the assertion macro header.
//
//  channel   prefix  direction  payload
//  circles   s_      in         in_t  (three centres, three squared radii)
//  result    m_      out        out_t (centre, orthogonal radius, flags)
//
// One request enters per cycle unless m_ready stalls the pipe; 46 register stages:
// six front stages (input, squares, power terms, determinant, numerators,
// magnitudes), 37 divider stages (a load stage, then one quotient bit each)
// and three back stages.
// Reset (aresetn low, synchronous) clears all valid bits.
// Each stage holds while its successor is full and stalled; bubbles close up.
`include "orthogonal_circle_of_three_circles_defines.svh"

module orthogonal_circle_of_three_circles import ocotc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int MW  = QuotW + 1;
    localparam int DxW = QuotW + 2;
    localparam int SW  = 2 * CentreW - OutFrac + 2;

    typedef struct packed {
        logic [SqW-1:0]               sax, say, sbx, sby, scx, scy;
        logic signed [DiffW-1:0]      dy1, dy2, dy3, dx1, dx2, dx3;
        logic signed [CoordWidth-1:0] bx, cx;
        logic [RadSqWidth-1:0]        br, cr;
        tag_t                         tag;
    } s2_t;

    typedef struct packed {
        logic signed [PowW-1:0]    pa, pb, pc;
        logic signed [DiffW-1:0]   dy1, dy2, dy3, dx1, dx2, dx3;
        logic signed [DdTermW-1:0] t1, t2, t3;
        tag_t                      tag;
    } s3_t;

    typedef struct packed {
        logic signed [DdW-1:0]    dd;
        logic signed [NTermW-1:0] x1, x2, x3, y1, y2, y3;
        tag_t                     tag;
    } s4_t;

    typedef struct packed {
        logic signed [DdW-1:0] dd;
        logic signed [NW-1:0]  nx, ny;
        tag_t                  tag;
    } s5_t;

    typedef struct packed {
        logic                      sat;
        logic signed [CentreW-1:0] val;
        logic                      big;
        logic [CentreW-1:0]        u;
    } post_t;

    typedef struct packed {
        logic signed [CentreW-1:0] ox, oy;
        logic                      csat, big, deg;
        logic [CentreW-1:0]        ux, uy;
        logic [RadSqWidth-1:0]     ar;
    } q1_t;

    typedef struct packed {
        logic signed [CentreW-1:0] ox, oy;
        logic                      csat, big, deg;
        logic [2*CentreW-1:0]      sx, sy;
        logic [RadSqWidth-1:0]     ar;
    } q2_t;

    in_t        p1_reg;
    s2_t        p2_reg, p2_next;
    s3_t        p3_reg, p3_next;
    s4_t        p4_reg, p4_next;
    s5_t        p5_reg, p5_next;
    div_req_t   p6_reg, p6_next;
    q1_t        q1_reg, q1_next;
    q2_t        q2_reg, q2_next;
    out_t       out_reg, out_next;
    logic       v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic       vq1_reg, vq2_reg, vo_reg;
    logic       en1, en2, en3, en4, en5, en6, enq1, enq2, eno;
    logic       div_ready, div_valid;
    div_stage_t div_rsp;

    function automatic logic [SqW-1:0] sq_of(logic signed [CoordWidth-1:0] a);
        logic signed [2*CoordWidth-1:0] p;
        p = a * a;
        return p[SqW-1:0];
    endfunction

    function automatic logic signed [DiffW-1:0] diff_of(logic signed [CoordWidth-1:0] a,
                                                        logic signed [CoordWidth-1:0] b);
        logic signed [DiffW-1:0] ea, eb;
        ea = DiffW'(a);
        eb = DiffW'(b);
        return ea - eb;
    endfunction

    function automatic logic signed [PowW-1:0] pow_of(logic [SqW-1:0] sx, logic [SqW-1:0] sy,
                                                      logic [RadSqWidth-1:0] r);
        logic signed [PowW-1:0] a, b, c;
        a = $signed({{(PowW-SqW){1'b0}}, sx});
        b = $signed({{(PowW-SqW){1'b0}}, sy});
        c = $signed({{(PowW-RadSqWidth){1'b0}}, r});
        return a + b - c;
    endfunction

    // signed quotient, offset from the first centre, centre clamp
    function automatic post_t post_of(lane_t l, logic signed [CoordWidth-1:0] a);
        logic signed [MW-1:0]  m, hi_lim, lo_lim;
        logic signed [DxW-1:0] d, ea;
        logic [DxW-1:0]        u;
        post_t                 p;
        m      = l.neg ? -$signed({1'b0, l.lo}) : $signed({1'b0, l.lo});
        hi_lim = MW'(CentreMax);
        lo_lim = MW'(CentreMin);
        ea     = DxW'(a);
        d      = DxW'(m) - (ea <<< ScaleShift);
        u      = d[DxW-1] ? DxW'(-d) : d;
        p.big  = l.ov || (|u[DxW-1:CentreW]);
        p.u    = u[CentreW-1:0];
        priority if (l.ov) begin
            p.sat = 1'b1;
            p.val = l.neg ? CentreMin : CentreMax;
        end else if (m > hi_lim) begin
            p.sat = 1'b1;
            p.val = CentreMax;
        end else if (m < lo_lim) begin
            p.sat = 1'b1;
            p.val = CentreMin;
        end else begin
            p.sat = 1'b0;
            p.val = m[CentreW-1:0];
        end
        return p;
    endfunction

    // stall chain, back to front
    assign eno  = !vo_reg  || m_ready;
    assign enq2 = !vq2_reg || eno;
    assign enq1 = !vq1_reg || enq2;
    assign en6  = !v6_reg  || div_ready;
    assign en5  = !v5_reg  || en6;
    assign en4  = !v4_reg  || en5;
    assign en3  = !v3_reg  || en4;
    assign en2  = !v2_reg  || en3;
    assign en1  = !v1_reg  || en2;
    assign s_ready = en1;

    // stage 2: squares and coordinate differences
    always_comb begin
        p2_next.sax = sq_of(p1_reg.first_x);
        p2_next.say = sq_of(p1_reg.first_y);
        p2_next.sbx = sq_of(p1_reg.second_x);
        p2_next.sby = sq_of(p1_reg.second_y);
        p2_next.scx = sq_of(p1_reg.third_x);
        p2_next.scy = sq_of(p1_reg.third_y);
        p2_next.dy1 = diff_of(p1_reg.second_y, p1_reg.third_y);
        p2_next.dy2 = diff_of(p1_reg.third_y, p1_reg.first_y);
        p2_next.dy3 = diff_of(p1_reg.first_y, p1_reg.second_y);
        p2_next.dx1 = diff_of(p1_reg.second_x, p1_reg.third_x);
        p2_next.dx2 = diff_of(p1_reg.third_x, p1_reg.first_x);
        p2_next.dx3 = diff_of(p1_reg.first_x, p1_reg.second_x);
        p2_next.bx  = p1_reg.second_x;
        p2_next.cx  = p1_reg.third_x;
        p2_next.br  = p1_reg.second_radius_sq;
        p2_next.cr  = p1_reg.third_radius_sq;
        p2_next.tag = '{deg: 1'b0, ax: p1_reg.first_x, ay: p1_reg.first_y,
                        ar: p1_reg.first_radius_sq};
    end

    // stage 3: power terms and determinant products
    always_comb begin
        p3_next.pa  = pow_of(p2_reg.sax, p2_reg.say, p2_reg.tag.ar);
        p3_next.pb  = pow_of(p2_reg.sbx, p2_reg.sby, p2_reg.br);
        p3_next.pc  = pow_of(p2_reg.scx, p2_reg.scy, p2_reg.cr);
        p3_next.dy1 = p2_reg.dy1;
        p3_next.dy2 = p2_reg.dy2;
        p3_next.dy3 = p2_reg.dy3;
        p3_next.dx1 = p2_reg.dx1;
        p3_next.dx2 = p2_reg.dx2;
        p3_next.dx3 = p2_reg.dx3;
        p3_next.t1  = DdTermW'(p2_reg.tag.ax) * DdTermW'(p2_reg.dy1);
        p3_next.t2  = DdTermW'(p2_reg.bx) * DdTermW'(p2_reg.dy2);
        p3_next.t3  = DdTermW'(p2_reg.cx) * DdTermW'(p2_reg.dy3);
        p3_next.tag = p2_reg.tag;
    end

    // stage 4: determinant sum and numerator products
    always_comb begin
        p4_next.dd  = DdW'(p3_reg.t1) + DdW'(p3_reg.t2) + DdW'(p3_reg.t3);
        p4_next.x1  = NTermW'(p3_reg.dy1) * NTermW'(p3_reg.pa);
        p4_next.x2  = NTermW'(p3_reg.dy2) * NTermW'(p3_reg.pb);
        p4_next.x3  = NTermW'(p3_reg.dy3) * NTermW'(p3_reg.pc);
        p4_next.y1  = NTermW'(p3_reg.dx1) * NTermW'(p3_reg.pa);
        p4_next.y2  = NTermW'(p3_reg.dx2) * NTermW'(p3_reg.pb);
        p4_next.y3  = NTermW'(p3_reg.dx3) * NTermW'(p3_reg.pc);
        p4_next.tag = p3_reg.tag;
    end

    // stage 5: numerator sums
    always_comb begin
        p5_next.dd  = p4_reg.dd;
        p5_next.nx  = NW'(p4_reg.x1) + NW'(p4_reg.x2) + NW'(p4_reg.x3);
        p5_next.ny  = NW'(p4_reg.y1) + NW'(p4_reg.y2) + NW'(p4_reg.y3);
        p5_next.tag = p4_reg.tag;
    end

    // stage 6: magnitudes, scaling and half-divisor rounding offset
    always_comb begin
        logic [NW-1:0]  mnx, mny;
        logic [DdW-1:0] mdd;
        logic           ddneg;
        mnx   = p5_reg.nx[NW-1] ? NW'(-p5_reg.nx) : p5_reg.nx;
        mny   = p5_reg.ny[NW-1] ? NW'(-p5_reg.ny) : p5_reg.ny;
        mdd   = p5_reg.dd[DdW-1] ? DdW'(-p5_reg.dd) : p5_reg.dd;
        ddneg = p5_reg.dd[DdW-1];
        p6_next.un_x    = (UnW'(mnx) << ScaleShift) + UnW'(mdd);
        p6_next.un_y    = (UnW'(mny) << ScaleShift) + UnW'(mdd);
        p6_next.neg_x   = p5_reg.nx[NW-1] ^ ddneg;
        p6_next.neg_y   = !p5_reg.ny[NW-1] ^ ddneg;
        p6_next.den     = {mdd, 1'b0};
        p6_next.tag     = p5_reg.tag;
        p6_next.tag.deg = (p5_reg.dd == '0);
    end

    ocotc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (v6_reg),
        .req_ready (div_ready),
        .req       (p6_reg),
        .rsp_valid (div_valid),
        .rsp_ready (enq1),
        .rsp       (div_rsp)
    );

    // back stage 1: centre and offsets from the first circle
    always_comb begin
        post_t px, py;
        px = post_of(div_rsp.x, div_rsp.tag.ax);
        py = post_of(div_rsp.y, div_rsp.tag.ay);
        q1_next.ox   = px.val;
        q1_next.oy   = py.val;
        q1_next.csat = px.sat || py.sat;
        q1_next.big  = px.big || py.big;
        q1_next.deg  = div_rsp.tag.deg;
        q1_next.ux   = px.u;
        q1_next.uy   = py.u;
        q1_next.ar   = div_rsp.tag.ar;
    end

    // back stage 2: squares of the offsets
    always_comb begin
        q2_next.ox   = q1_reg.ox;
        q2_next.oy   = q1_reg.oy;
        q2_next.csat = q1_reg.csat;
        q2_next.big  = q1_reg.big;
        q2_next.deg  = q1_reg.deg;
        q2_next.sx   = (2*CentreW)'(q1_reg.ux) * (2*CentreW)'(q1_reg.ux);
        q2_next.sy   = (2*CentreW)'(q1_reg.uy) * (2*CentreW)'(q1_reg.uy);
        q2_next.ar   = q1_reg.ar;
    end

    // back stage 3: radius, clamp, collinear override
    always_comb begin
        logic [SW-1:0]        s;
        logic [OutFrac:0]     fs;
        logic signed [SW:0]   r;
        logic signed [SW:0]   rmax;
        logic                 rsat;
        logic signed [RadW-1:0] rad;
        fs   = (OutFrac+1)'(q2_reg.sx[OutFrac-1:0]) + (OutFrac+1)'(q2_reg.sy[OutFrac-1:0]);
        s    = SW'(q2_reg.sx[2*CentreW-1:OutFrac]) + SW'(q2_reg.sy[2*CentreW-1:OutFrac])
             + SW'(fs[OutFrac]);
        r    = $signed({1'b0, s}) - $signed({{(SW+1-RadSqWidth){1'b0}}, q2_reg.ar});
        rmax = (SW+1)'(RadMax);
        priority if (q2_reg.big) begin
            rsat = 1'b1;
            rad  = RadMax;
        end else if (r > rmax) begin
            rsat = 1'b1;
            rad  = RadMax;
        end else begin
            rsat = 1'b0;
            rad  = r[RadW-1:0];
        end
        if (q2_reg.deg) begin
            out_next = '{centre_x: '0, centre_y: '0, orth_radius_sq: '0,
                         degenerate: 1'b1, saturated: 1'b0};
        end else begin
            out_next = '{centre_x: q2_reg.ox, centre_y: q2_reg.oy, orth_radius_sq: rad,
                         degenerate: 1'b0, saturated: q2_reg.csat || rsat};
        end
    end

    // advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            vq1_reg <= 1'b0;
            vq2_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end else begin
            if (en1)  v1_reg  <= s_valid;
            if (en2)  v2_reg  <= v1_reg;
            if (en3)  v3_reg  <= v2_reg;
            if (en4)  v4_reg  <= v3_reg;
            if (en5)  v5_reg  <= v4_reg;
            if (en6)  v6_reg  <= v5_reg;
            if (enq1) vq1_reg <= div_valid;
            if (enq2) vq2_reg <= vq1_reg;
            if (eno)  vo_reg  <= vq2_reg;
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en1)  p1_reg  <= s_data;
        if (en2)  p2_reg  <= p2_next;
        if (en3)  p3_reg  <= p3_next;
        if (en4)  p4_reg  <= p4_next;
        if (en5)  p5_reg  <= p5_next;
        if (en6)  p6_reg  <= p6_next;
        if (enq1) q1_reg  <= q1_next;
        if (enq2) q2_reg  <= q2_next;
        if (eno)  out_reg <= out_next;
    end

    assign m_valid = vo_reg;
    assign m_data  = out_reg;

    `OCOTC_ASSERT_IMPLY(a_deg_zero, aclk, aresetn, m_valid && m_data.degenerate, m_data.centre_x == '0 && m_data.centre_y == '0 && m_data.orth_radius_sq == '0 && !m_data.saturated)
    `OCOTC_ASSERT_IMPLY(a_empty_ready, aclk, aresetn, !m_valid, s_ready)
    `OCOTC_ASSERT_NEXT(a_reset_clear, aclk, !aresetn, !m_valid)

endmodule
